>>> rtl/core/utlc_pkg.sv
// shared types and codes for the uart transmit line console
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package utlc_pkg;

  // bus access opcodes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // register offsets inside the uart window
  localparam logic [2:0] REG_RBR_THR = 3'd0;
  localparam logic [2:0] REG_IER     = 3'd1;
  localparam logic [2:0] REG_IIR     = 3'd2;
  localparam logic [2:0] REG_LCR     = 3'd3;
  localparam logic [2:0] REG_MCR     = 3'd4;
  localparam logic [2:0] REG_LSR     = 3'd5;
  localparam logic [2:0] REG_MSR     = 3'd6;
  localparam logic [2:0] REG_SCR     = 3'd7;

  localparam logic [3:0] SIZE_BYTE = 4'd1;
  localparam logic [3:0] SIZE_WORD = 4'd4;

  localparam int unsigned LCR_DLAB_BIT = 7;
  localparam logic [7:0] IIR_NO_INT      = 8'h01;
  localparam logic [7:0] LSR_HOLD_EMPTY  = 8'h20;
  localparam logic [7:0] LSR_SHIFT_EMPTY = 8'h40;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // result kinds
  localparam logic RES_READ    = 1'b0;
  localparam logic RES_CONSOLE = 1'b1;

  // command queue between front and back
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_AW    = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CW    = $clog2(CMD_DEPTH + 1);

  typedef enum logic {
    CMD_READ = 1'b0,
    CMD_TX   = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/utlc_front.sv
// front end: accepts bus accesses, holds the uart register file and
// queues read replies and transmit characters; uses utlc_pkg
`timescale 1ns / 1ps
`default_nettype none

module utlc_front import utlc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic       in_opcode,
  input  wire logic [2:0] in_register_offset,
  input  wire logic [3:0] in_access_size,
  input  wire logic [7:0] in_write_data,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  logic [7:0] ier_r, lcr_r, mcr_r, scr_r, dll_r, dlm_r;
  logic       accept;
  logic       size_ok;
  logic       dlab;
  logic       is_write;
  logic [7:0] rd_data;

  assign accept   = in_push && !q_full;
  assign size_ok  = (in_access_size == SIZE_BYTE) || (in_access_size == SIZE_WORD);
  assign dlab     = lcr_r[LCR_DLAB_BIT];
  assign is_write = (in_opcode == OP_WRITE);

  always_comb begin
    rd_data = 8'h00;
    if (size_ok) begin
      unique case (in_register_offset)
        REG_RBR_THR: rd_data = dlab ? dll_r : 8'h00;
        REG_IER:     rd_data = dlab ? dlm_r : ier_r;
        REG_IIR:     rd_data = IIR_NO_INT;
        REG_LCR:     rd_data = lcr_r;
        REG_MCR:     rd_data = mcr_r;
        REG_LSR:     rd_data = LSR_HOLD_EMPTY | LSR_SHIFT_EMPTY;
        REG_MSR:     rd_data = 8'h00;
        REG_SCR:     rd_data = scr_r;
      endcase
    end
  end

  // reads always queue a reply, writes only queue transmit characters
  assign q_push = accept && (!is_write ||
                  (size_ok && in_register_offset == REG_RBR_THR && !dlab));

  always_comb begin
    if (is_write) begin
      q_cmd.kind = CMD_TX;
      q_cmd.data = in_write_data;
    end else begin
      q_cmd.kind = CMD_READ;
      q_cmd.data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ier_r <= 8'h00;
      lcr_r <= 8'h00;
      mcr_r <= 8'h00;
      scr_r <= 8'h00;
      dll_r <= 8'h00;
      dlm_r <= 8'h00;
    end else if (accept && is_write && size_ok) begin
      unique case (in_register_offset)
        REG_RBR_THR: if (dlab) dll_r <= in_write_data;
        REG_IER: begin
          if (dlab) dlm_r <= in_write_data;
          else ier_r <= in_write_data;
        end
        REG_LCR:     lcr_r <= in_write_data;
        REG_MCR:     mcr_r <= in_write_data;
        REG_SCR:     scr_r <= in_write_data;
        REG_IIR, REG_LSR, REG_MSR: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/utlc_cmd_fifo.sv
// short command queue between the front end and the console back end
// uses cmd_t and the queue depth from utlc_pkg
`timescale 1ns / 1ps
`default_nettype none

module utlc_cmd_fifo import utlc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output cmd_t      head
);

  cmd_t              slots_r [CMD_DEPTH];
  logic [CMD_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_CW-1:0] count_r;
  logic              do_push, do_pop;

  assign full    = (count_r == CMD_CW'(CMD_DEPTH));
  assign valid   = (count_r != '0);
  assign head    = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + CMD_AW'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + CMD_AW'(1);
      if (do_push && !do_pop) count_r <= count_r + CMD_CW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CMD_CW'(1);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/utlc_back.sv
// back end: line store, prompt detection and flush sequencer feeding the
// result register; uses utlc_pkg
`timescale 1ns / 1ps
`default_nettype none

module utlc_back import utlc_pkg::*; #(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire cmd_t q_cmd,
  output logic      q_pop,
  input  wire logic out_pop,
  output logic      out_empty,
  output logic      out_result_kind,
  output logic [7:0] out_data_byte,
  output logic      out_last_of_run
);

  localparam int unsigned FW = $clog2(LINE_DEPTH + 1);
  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned TAIL_LEN = 10;

  localparam logic [6:0][7:0] SFX_LOGIN = "login: ";
  localparam logic [9:0][7:0] SFX_PASS  = "Password: ";
  localparam logic [1:0][7:0] SFX_ROOT  = "# ";
  localparam logic [1:0][7:0] SFX_USER  = "$ ";

  typedef enum logic [1:0] {
    S_IDLE,
    S_STORE,
    S_FLUSH,
    S_NL
  } state_t;

  state_t state_r;
  logic [7:0] line_mem [LINE_DEPTH];
  logic [7:0] rd_data_r;
  logic [FW-1:0] fill_r, ptr_r, fill_inc;
  logic [TAIL_LEN-1:0][7:0] tail_r, tail_new;
  logic [7:0] char_r;
  logic nl_r, store_after_r, pend_r, pend_last_r;
  logic out_valid_r, out_kind_r, out_last_r;
  logic [7:0] out_data_r;
  logic slot_free, adv, issue, hit, load;

  assign slot_free = !out_valid_r || out_pop;
  assign adv       = (state_r == S_FLUSH) && pend_r && slot_free;
  assign issue     = (state_r == S_FLUSH) && (ptr_r < fill_r) && (!pend_r || adv);
  assign q_pop     = (state_r == S_IDLE) && q_valid &&
                     (q_cmd.kind == CMD_TX || slot_free);
  // result register takes a new beat this cycle
  assign load      = adv || (slot_free && (state_r == S_NL ||
                     (state_r == S_IDLE && q_valid && q_cmd.kind == CMD_READ)));

  // tail holds the newest characters, newest at index 0
  assign tail_new = {tail_r[TAIL_LEN-2:0], char_r};
  assign fill_inc = fill_r + FW'(1);
  assign hit = (fill_inc >= FW'(7) && tail_new[6:0] == SFX_LOGIN) ||
               (fill_inc >= FW'(10) && tail_new == SFX_PASS) ||
               (fill_inc >= FW'(2) &&
                (tail_new[1:0] == SFX_ROOT || tail_new[1:0] == SFX_USER));

  always_ff @(posedge clk) begin
    if (state_r == S_STORE) line_mem[fill_r[AW-1:0]] <= char_r;
    if (issue) rd_data_r <= line_mem[ptr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_STORE) tail_r <= tail_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      fill_r        <= '0;
      ptr_r         <= '0;
      pend_r        <= 1'b0;
      pend_last_r   <= 1'b0;
      nl_r          <= 1'b0;
      store_after_r <= 1'b0;
      char_r        <= 8'h00;
      out_valid_r   <= 1'b0;
      out_kind_r    <= RES_READ;
      out_data_r    <= 8'h00;
      out_last_r    <= 1'b0;
    end else begin
      if (load) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_cmd.kind == CMD_READ) begin
              if (slot_free) begin
                out_kind_r  <= RES_READ;
                out_data_r  <= q_cmd.data;
                out_last_r  <= 1'b1;
              end
            end else begin
              char_r <= q_cmd.data;
              ptr_r  <= '0;
              if (q_cmd.data == CH_CR) begin
                state_r <= S_IDLE;
              end else if (q_cmd.data == CH_LF) begin
                if (fill_r != '0) begin
                  nl_r          <= 1'b1;
                  store_after_r <= 1'b0;
                  state_r       <= S_FLUSH;
                end
              end else if (fill_r == FW'(LINE_DEPTH)) begin
                // full line goes out with a newline before the new character
                nl_r          <= 1'b1;
                store_after_r <= 1'b1;
                state_r       <= S_FLUSH;
              end else begin
                state_r <= S_STORE;
              end
            end
          end
        end
        S_STORE: begin
          fill_r <= fill_inc;
          ptr_r  <= '0;
          if (hit) begin
            nl_r          <= 1'b0;
            store_after_r <= 1'b0;
            state_r       <= S_FLUSH;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (issue) begin
            ptr_r       <= ptr_r + FW'(1);
            pend_r      <= 1'b1;
            pend_last_r <= (ptr_r == fill_r - FW'(1));
          end else if (adv) begin
            pend_r <= 1'b0;
          end
          if (adv) begin
            out_kind_r  <= RES_CONSOLE;
            out_data_r  <= rd_data_r;
            out_last_r  <= pend_last_r && !nl_r;
            if (pend_last_r) begin
              if (nl_r) begin
                state_r <= S_NL;
              end else begin
                fill_r  <= '0;
                state_r <= S_IDLE;
              end
            end
          end
        end
        S_NL: begin
          if (slot_free) begin
            out_kind_r  <= RES_CONSOLE;
            out_data_r  <= CH_LF;
            out_last_r  <= 1'b1;
            fill_r      <= '0;
            state_r     <= store_after_r ? S_STORE : S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_data_byte   = out_data_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

>>> rtl/core/uart16550_tx_line_console.sv
// top level of the uart transmit line console: front end, command queue
// and back end; depends on utlc_pkg, utlc_front, utlc_cmd_fifo, utlc_back
//
// usage:
//   input channel: one bus access per beat (in_push / in_full). reads give
//   one reply beat, transmit writes give zero or more console beats,
//   other writes update the register file and give nothing.
//   result channel: out_empty / out_pop, oldest beat on the out_ ports;
//   out_last_of_run marks the final beat caused by one access.
// read path: a read reply is written into the command queue and then
//   into the result register, which drives the result ports.
// throughput: the front takes one access per cycle until the 4-deep
//   command queue fills. the back handles a read in its idle state, a
//   stored character in the idle and then the store state, and a flush by
//   priming the line store read, then sending each character and then,
//   when the flush closes a line, the newline; a full line flushed before
//   a new character goes on to store that character after the newline.
// reset: synchronous, clears registers, line fill and queue; no sweep.
// stall: while out_pop is low the result register holds, the sequencer
//   waits, and in_full rises once the command queue is full.
`timescale 1ns / 1ps
`default_nettype none

module uart16550_tx_line_console import utlc_pkg::*; #(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic       in_opcode,
  input  wire logic [2:0] in_register_offset,
  input  wire logic [3:0] in_access_size,
  input  wire logic [7:0] in_write_data,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic            out_result_kind,
  output logic [7:0]      out_data_byte,
  output logic            out_last_of_run
);

  logic q_push, q_full, q_valid, q_pop;
  cmd_t q_in_cmd, q_head;

  assign in_full = q_full;

  utlc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_opcode          (in_opcode),
    .in_register_offset (in_register_offset),
    .in_access_size     (in_access_size),
    .in_write_data      (in_write_data),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_cmd              (q_in_cmd)
  );

  utlc_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  utlc_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_head),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_result_kind (out_result_kind),
    .out_data_byte   (out_data_byte),
    .out_last_of_run (out_last_of_run)
  );

  // a read reply is always alone in its run
  a_read_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_result_kind == RES_READ) |-> out_last_of_run)
    else $error("read reply without last flag");

  // cr is dropped and never stored, so it can never be flushed
  a_no_cr_out: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_result_kind == RES_CONSOLE) |-> (out_data_byte != CH_CR))
    else $error("carriage return reached the console");

  // lf is never stored; it only appears as the closing newline of a flush
  a_lf_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_result_kind == RES_CONSOLE && out_data_byte == CH_LF)
      |-> out_last_of_run)
    else $error("newline not at end of run");

  // a waiting result is not dropped while the receiver stalls
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("stalled result lost");

endmodule

`default_nettype wire
